@@ rtl/core/adaptive_noise_gate_vad_core_macros.svh @@
// Assertion helpers shared by the checkers of the voice activity core.
`ifndef ADAPTIVE_NOISE_GATE_VAD_CORE_MACROS_SVH
`define ADAPTIVE_NOISE_GATE_VAD_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ANGVAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ANGVAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/angvad_pkg.sv @@
// ----------------------------------------------------------------------------
// angvad_pkg
// Types, widths and constants of the adaptive noise gate voice activity core.
// ----------------------------------------------------------------------------
package angvad_pkg;

   localparam int unsigned MAX_CHUNK  = 4096;
   localparam int unsigned CNT_W      = $clog2(MAX_CHUNK + 1);
   localparam int unsigned SMP_W      = 16;
   localparam int unsigned MAG_W      = SMP_W + 1;
   localparam int unsigned SUM_W      = 2 * SMP_W - 1 + CNT_W - 1;
   localparam int unsigned ELAP_W     = 24;
   localparam int unsigned FLOOR_W    = 24;
   localparam int unsigned GATE_W     = 20;
   localparam int unsigned G6_W       = GATE_W + 3;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned LOUD_W     = 17;
   localparam int unsigned MUL_A_W    = 24;
   localparam int unsigned MUL_B_W    = 17;
   localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int unsigned DIV_N_W    = SUM_W;
   localparam int unsigned DIV_D_W    = 24;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_N_W);
   localparam int unsigned SQ_W       = 31;
   localparam int unsigned ROOT_CNT_W = 4;
   localparam int unsigned ROOT_TOP   = SQ_W - 1;

   localparam logic [CNT_W-1:0]     CHUNK_FULL = CNT_W'(MAX_CHUNK);
   localparam logic [ELAP_W-1:0]    ELAP_MAX   = '1;
   localparam logic [LOUD_W-1:0]    LOUD_ONE   = LOUD_W'(65536);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(DIV_N_W - 1);

   localparam logic [23:0] RST_ENDPOINT  = 24'd12800;
   localparam logic [15:0] RST_CALIBRATE = 16'd4800;
   localparam logic [15:0] RST_ANNOUNCE  = 16'd6400;
   localparam logic [7:0]  RST_GAIN      = 8'd48;
   localparam logic [15:0] RST_RATE      = 16'd3277;
   localparam logic [15:0] RST_GATE_MIN  = 16'd131;
   localparam logic [15:0] RST_FLOOR_MAX = 16'd655;

   typedef enum logic [2:0] {
      CSR_ENDPOINT,
      CSR_CALIBRATE,
      CSR_ANNOUNCE,
      CSR_GAIN,
      CSR_RATE,
      CSR_GATE_MIN,
      CSR_FLOOR_MAX
   } csr_index_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    chunk_last;
      logic                    restart;
   } req_type;

   typedef struct packed {
      logic                voice_present;
      logic [LEVEL_W-1:0]  level;
      logic [15:0]         gate_level;
      logic [LOUD_W-1:0]   loudness;
      logic [ELAP_W-1:0]   quiet_samples;
      logic                may_end;
      logic                may_announce;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_ROOT,
      ST_GATE_MUL,
      ST_GATE,
      ST_FLOOR_MUL,
      ST_FLOOR,
      ST_LOUD_START,
      ST_LOUD_WAIT,
      ST_RESULT
   } state_type;

endpackage

@@ rtl/core/angvad_div.sv @@
// ----------------------------------------------------------------------------
// angvad_div
// Restoring divider, one quotient bit per cycle, shared by the mean-square
// and loudness divisions.
// ----------------------------------------------------------------------------
module angvad_div
   import angvad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_D_W'(shifted - {1'b0, dsr_ff}) : shifted[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/core/adaptive_noise_gate_vad_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_noise_gate_vad_core
// Energy voice activity detector with an adaptive noise floor.
// ----------------------------------------------------------------------------
// Takes one signed Q1.15 sample per req word and returns one rsp word per
// chunk, at the sample marked chunk_last or at the 4096th sample of a chunk.
// A sample that does not close a chunk passes the accept, square and
// accumulate steps. A closing sample then also takes two passes of the
// shared one-bit-per-cycle divider (for the mean square and the loudness
// ratio; the second pass is skipped when the gate is zero), a 16-step
// square root, and the shared 24x17 multiplier for the gate and the floor
// step. It also waits in its result state while the previous rsp word is
// still held. req_ready is low while a sample is at work; a finished rsp
// word waits in its own register, so the next samples are taken meanwhile.
// csr writes are taken in any cycle and should be made only while the
// block is idle.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_vad_core
   import angvad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   // configuration
   logic [23:0] cfg_end_ff;
   logic [15:0] cfg_cal_ff, cfg_gap_ff, cfg_rate_ff, cfg_gmin_ff, cfg_fmax_ff;
   logic [7:0]  cfg_gain_ff;

   // control and state
   state_type            state_ff, state_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ELAP_W-1:0]    elapsed_ff, elapsed_in;
   logic [ELAP_W-1:0]    last_voice_ff, last_voice_in;
   logic [FLOOR_W-1:0]   floor_ff, floor_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic                  last_ff, last_in;
   logic [MUL_P_W-1:0]    prod_ff, prod_in;
   logic [SQ_W-1:0]       rem_ff, rem_in;
   logic [SQ_W-1:0]       res_ff, res_in;
   logic [ROOT_CNT_W-1:0] iter_ff, iter_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [GATE_W-1:0]     gate_ff, gate_in;
   logic [FLOOR_W-1:0]    diff_ff, diff_in;
   logic                  up_ff, up_in;
   logic                  calib_ff, calib_in;
   logic                  pass_ff, pass_in;
   logic                  voice_ff, voice_in;
   logic [LOUD_W-1:0]     loud_ff, loud_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [CNT_W-1:0]   count_next;
   logic [SQ_W-1:0]    root_bit;
   logic [SQ_W:0]      root_trial;
   logic [SQ_W-1:0]    root_res;
   logic [4:0]         root_shift;
   logic [GATE_W-1:0]  gate_val;
   logic [FLOOR_W-1:0] target;
   logic [FLOOR_W-1:0] cap;
   logic [FLOOR_W-1:0] raised;
   logic [FLOOR_W-1:0] step;
   logic [G6_W-1:0]    gate6;
   logic [ELAP_W-1:0]  quiet;
   logic               calib_now;
   logic               voice_now;

   angvad_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mul_p = mul_a * mul_b;

   always_comb begin
      count_next = count_ff + 1'b1;
      root_shift = 5'(ROOT_TOP) - {iter_ff, 1'b0};
      root_bit   = SQ_W'(1) << root_shift;
      root_trial = {1'b0, res_ff} + {1'b0, root_bit};
      root_res   = (rem_ff >= root_trial[SQ_W-1:0] && !root_trial[SQ_W])
                   ? ((res_ff >> 1) + root_bit) : (res_ff >> 1);
      gate_val   = (prod_ff[31:12] > {4'b0, cfg_gmin_ff}) ? prod_ff[31:12]
                                                        : {4'b0, cfg_gmin_ff};
      target     = {level_ff, 8'b0};
      cap        = {cfg_fmax_ff, 8'b0};
      raised     = (target > floor_ff) ? target : floor_ff;
      step       = prod_ff[FLOOR_W+15:16];
      gate6      = G6_W'({gate_ff, 2'b00}) + G6_W'({gate_ff, 1'b0});
      quiet      = elapsed_ff - last_voice_ff;
      calib_now  = elapsed_ff < {8'b0, cfg_cal_ff};
      voice_now  = ({4'b0, level_ff} > gate_ff) || calib_ff;
   end

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      elapsed_in    = elapsed_ff;
      last_voice_in = last_voice_ff;
      floor_in      = floor_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      mag_in        = mag_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      res_in        = res_ff;
      iter_in       = iter_ff;
      level_in      = level_ff;
      gate_in       = gate_ff;
      diff_in       = diff_ff;
      up_in         = up_ff;
      calib_in      = calib_ff;
      pass_in       = pass_ff;
      voice_in      = voice_ff;
      loud_in       = loud_ff;
      rsp_data_in   = rsp_data_ff;
      req_ready     = 1'b0;
      mul_a         = floor_ff;
      mul_b         = MUL_B_W'(cfg_gain_ff);
      div_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.restart) begin
                  floor_in      = '0;
                  elapsed_in    = '0;
                  last_voice_in = '0;
                  sum_in        = '0;
                  count_in      = '0;
               end
               mag_in   = req_data.sample[SMP_W-1]
                          ? MAG_W'(17'h10000 - {1'b0, req_data.sample})
                          : {1'b0, req_data.sample};
               last_in  = req_data.chunk_last;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mul_a    = MUL_A_W'(mag_ff);
            mul_b    = mag_ff;
            prod_in  = mul_p;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in   = sum_ff + SUM_W'(prod_ff);
            count_in = count_next;
            if (elapsed_ff != ELAP_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            state_in = (last_ff || count_next == CHUNK_FULL) ? ST_MEAN_START : ST_IDLE;
         end
         ST_MEAN_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = DIV_D_W'(count_ff);
            sum_in           = '0;
            count_in         = '0;
            state_in         = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               // mean square never exceeds 2^30
               rem_in   = div_rsp.quotient[SQ_W-1:0];
               res_in   = '0;
               iter_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rem_ff >= root_trial[SQ_W-1:0] && !root_trial[SQ_W]) begin
               rem_in = rem_ff - root_trial[SQ_W-1:0];
            end
            res_in  = root_res;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == '1) begin
               level_in = root_res[LEVEL_W-1:0];
               pass_in  = 1'b0;
               state_in = ST_GATE_MUL;
            end
         end
         ST_GATE_MUL: begin
            prod_in  = mul_p;
            state_in = ST_GATE;
         end
         ST_GATE: begin
            gate_in = gate_val;
            if (pass_ff) begin
               state_in = ST_LOUD_START;
            end else begin
               calib_in = calib_now;
               if (calib_now) begin
                  floor_in = (raised > cap) ? cap : raised;
                  pass_in  = 1'b1;
                  state_in = ST_GATE_MUL;
               end else if ({4'b0, level_ff} < gate_val) begin
                  up_in    = target >= floor_ff;
                  diff_in  = (target >= floor_ff) ? (target - floor_ff) : (floor_ff - target);
                  state_in = ST_FLOOR_MUL;
               end else begin
                  state_in = ST_LOUD_START;
               end
            end
         end
         ST_FLOOR_MUL: begin
            mul_a    = diff_ff;
            mul_b    = MUL_B_W'(cfg_rate_ff);
            prod_in  = mul_p;
            state_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            floor_in = up_ff ? (floor_ff + step) : (floor_ff - step);
            state_in = ST_LOUD_START;
         end
         ST_LOUD_START: begin
            voice_in = voice_now;
            if (voice_now) begin
               last_voice_in = elapsed_ff;
            end
            if (gate_ff == '0) begin
               loud_in  = (level_ff != '0) ? LOUD_ONE : '0;
               state_in = ST_RESULT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N_W'({level_ff, 16'b0});
               div_req.divisor  = DIV_D_W'(gate6);
               state_in         = ST_LOUD_WAIT;
            end
         end
         ST_LOUD_WAIT: begin
            if (div_rsp.done) begin
               loud_in  = (div_rsp.quotient > DIV_N_W'(LOUD_ONE)) ? LOUD_ONE
                                                                  : div_rsp.quotient[LOUD_W-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.voice_present  = voice_ff;
               rsp_data_in.level          = level_ff;
               rsp_data_in.gate_level     = (gate_ff > GATE_W'(16'hFFFF)) ? 16'hFFFF
                                                                         : gate_ff[15:0];
               rsp_data_in.loudness       = loud_ff;
               rsp_data_in.quiet_samples  = quiet;
               rsp_data_in.may_end        = quiet >= cfg_end_ff;
               rsp_data_in.may_announce   = quiet >= {8'b0, cfg_gap_ff};
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         count_ff      <= '0;
         elapsed_ff    <= '0;
         last_voice_ff <= '0;
         floor_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         elapsed_ff    <= elapsed_in;
         last_voice_ff <= last_voice_in;
         floor_ff      <= floor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      iter_ff     <= iter_in;
      level_ff    <= level_in;
      gate_ff     <= gate_in;
      diff_ff     <= diff_in;
      up_ff       <= up_in;
      calib_ff    <= calib_in;
      pass_ff     <= pass_in;
      voice_ff    <= voice_in;
      loud_ff     <= loud_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers, masked to width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_end_ff  <= RST_ENDPOINT;
         cfg_cal_ff  <= RST_CALIBRATE;
         cfg_gap_ff  <= RST_ANNOUNCE;
         cfg_gain_ff <= RST_GAIN;
         cfg_rate_ff <= RST_RATE;
         cfg_gmin_ff <= RST_GATE_MIN;
         cfg_fmax_ff <= RST_FLOOR_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENDPOINT:  cfg_end_ff  <= csr_data;
            CSR_CALIBRATE: cfg_cal_ff  <= csr_data[15:0];
            CSR_ANNOUNCE:  cfg_gap_ff  <= csr_data[15:0];
            CSR_GAIN:      cfg_gain_ff <= csr_data[7:0];
            CSR_RATE:      cfg_rate_ff <= csr_data[15:0];
            CSR_GATE_MIN:  cfg_gmin_ff <= csr_data[15:0];
            CSR_FLOOR_MAX: cfg_fmax_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/angvad_checker.sv @@
// ----------------------------------------------------------------------------
// angvad_checker
// Port-level checks on the voice activity core, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_noise_gate_vad_core_macros.svh"

module angvad_checker
   import angvad_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `ANGVAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")
   `ANGVAD_ASSERT_NOW(a_loud_bound, rsp_valid, rsp_data.loudness <= LOUD_ONE, "loudness above one")
   `ANGVAD_ASSERT_NOW(a_voice_quiet, rsp_valid && rsp_data.voice_present, rsp_data.quiet_samples == '0, "voiced word with quiet time")
   `ANGVAD_ASSERT_NOW(a_silent_gate, rsp_valid && !rsp_data.voice_present, rsp_data.level <= rsp_data.gate_level, "silent word with level over gate")
   `ANGVAD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "req taken again while busy")

endmodule

bind adaptive_noise_gate_vad_core angvad_checker u_angvad_checker (.*);

@@ sim/adaptive_noise_gate_vad_core_test.sv @@
// ----------------------------------------------------------------------------
// adaptive_noise_gate_vad_core_test
// Self-checking bench for the voice activity core: a predictor tracks the
// chunk energy, noise floor and quiet timers, and every rsp word is compared
// with the oldest predicted chunk report. Directed corner cases come first,
// then randomized chunk traffic over several register settings.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_vad_core_test
   import angvad_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [23:0] endpoint;
      logic [23:0] calibrate;
      logic [23:0] announce;
      logic [23:0] gain;
      logic [23:0] rate;
      logic [23:0] gate_min;
      logic [23:0] floor_max;
   } gate_setup_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   // predictor copy of the registers
   logic [23:0] cfg_endpoint  = RST_ENDPOINT;
   logic [15:0] cfg_calibrate = RST_CALIBRATE;
   logic [15:0] cfg_announce  = RST_ANNOUNCE;
   logic [7:0]  cfg_gain      = RST_GAIN;
   logic [15:0] cfg_rate      = RST_RATE;
   logic [15:0] cfg_gate_min  = RST_GATE_MIN;
   logic [15:0] cfg_floor_max = RST_FLOOR_MAX;

   // predictor copy of the detector state
   longint unsigned energy_acc    = 0;
   int unsigned     chunk_len     = 0;
   logic [23:0]     elapsed       = '0;
   logic [23:0]     last_voice_at = '0;
   logic [23:0]     floor_q8      = '0;

   rsp_type reports_due[$];
   int      mismatches     = 0;
   int      words_checked  = 0;
   int      samples_sent   = 0;
   int      stalled_cycles = 0;
   bit      steady_run     = 1'b0;

   adaptive_noise_gate_vad_core i_dut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned root_floor(longint unsigned v);
      int unsigned     r;
      longint unsigned c;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         c = r | (1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic longint unsigned gate_now();
      longint unsigned g;
      g = (64'(floor_q8) * cfg_gain) >> 12;
      return (g > cfg_gate_min) ? g : 64'(cfg_gate_min);
   endfunction

   function automatic void take_sample(req_type w);
      int              s;
      longint unsigned mag, g6, ratio, gate_v;
      int unsigned     lvl;
      logic [23:0]     tgt, cap, quiet;
      bit              calib, voice;
      rsp_type         r;
      if (w.restart) begin
         floor_q8      = '0;
         elapsed       = '0;
         last_voice_at = '0;
         energy_acc    = 0;
         chunk_len     = 0;
      end
      s = $signed(w.sample);
      mag = (s < 0) ? -s : s;
      energy_acc += mag * mag;
      chunk_len++;
      if (elapsed != ELAP_MAX) elapsed++;
      if (!w.chunk_last && chunk_len < MAX_CHUNK) return;

      lvl = root_floor(energy_acc / chunk_len);
      energy_acc = 0;
      chunk_len  = 0;

      tgt    = 24'(lvl << 8);
      calib  = elapsed < cfg_calibrate;
      gate_v = gate_now();
      if (calib) begin
         // max-track the floor, capped, and use the refreshed gate
         cap = {cfg_floor_max, 8'h00};
         if (tgt > floor_q8) floor_q8 = tgt;
         if (floor_q8 > cap) floor_q8 = cap;
         gate_v = gate_now();
      end else if (lvl < gate_v) begin
         if (tgt >= floor_q8)
            floor_q8 = floor_q8 + 24'((64'(tgt - floor_q8) * cfg_rate) >> 16);
         else
            floor_q8 = floor_q8 - 24'((64'(floor_q8 - tgt) * cfg_rate) >> 16);
      end

      voice = (lvl > gate_v) || calib;
      if (voice) last_voice_at = elapsed;
      quiet = elapsed - last_voice_at;

      g6 = gate_v * 6;
      if (g6 == 0) begin
         ratio = (lvl != 0) ? 65536 : 0;
      end else begin
         ratio = (64'(lvl) << 16) / g6;
         if (ratio > 65536) ratio = 65536;
      end

      r.voice_present = voice;
      r.level         = 16'(lvl);
      r.gate_level    = (gate_v > 65535) ? 16'hFFFF : 16'(gate_v);
      r.loudness      = 17'(ratio);
      r.quiet_samples = quiet;
      r.may_end       = quiet >= cfg_endpoint;
      r.may_announce  = quiet >= cfg_announce;
      reports_due.insert(reports_due.size(), r);
   endfunction

   // ----------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      mismatches++;
      $display("mismatch in word %0d, %s: got %0h, expected %0h",
               words_checked, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (reports_due.size() == 0) begin
            report_mismatch("word with none expected", 24'(rsp_data.level), 24'h0);
         end else begin
            want = reports_due.pop_front();
            if (rsp_data.voice_present !== want.voice_present)
               report_mismatch("voice_present", 24'(rsp_data.voice_present),
                               24'(want.voice_present));
            if (rsp_data.level !== want.level)
               report_mismatch("level", 24'(rsp_data.level), 24'(want.level));
            if (rsp_data.gate_level !== want.gate_level)
               report_mismatch("gate_level", 24'(rsp_data.gate_level),
                               24'(want.gate_level));
            if (rsp_data.loudness !== want.loudness)
               report_mismatch("loudness", 24'(rsp_data.loudness), 24'(want.loudness));
            if (rsp_data.quiet_samples !== want.quiet_samples)
               report_mismatch("quiet_samples", rsp_data.quiet_samples,
                               want.quiet_samples);
            if (rsp_data.may_end !== want.may_end)
               report_mismatch("may_end", 24'(rsp_data.may_end), 24'(want.may_end));
            if (rsp_data.may_announce !== want.may_announce)
               report_mismatch("may_announce", 24'(rsp_data.may_announce),
                               24'(want.may_announce));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady_run || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ----------------------------------------------------------------- stimulus

   task automatic send_sample(logic [15:0] smp, bit last, bit rs);
      req_type w;
      int      gap;
      w.sample     = smp;
      w.chunk_last = last;
      w.restart    = rs;
      if (!steady_run && $urandom_range(99) < 12) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      take_sample(w);
      samples_sent++;
   endtask

   function automatic logic [15:0] pick_sample(int amp);
      int v;
      v = int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   task automatic send_chunk(int len, int amp, bit rs);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(amp), i == len - 1, rs && i == 0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_due.size() != 0);
   endtask

   // a sample that closes no chunk may still be in flight after the last word
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ENDPOINT:  cfg_endpoint  = val;
         CSR_CALIBRATE: cfg_calibrate = val[15:0];
         CSR_ANNOUNCE:  cfg_announce  = val[15:0];
         CSR_GAIN:      cfg_gain      = val[7:0];
         CSR_RATE:      cfg_rate      = val[15:0];
         CSR_GATE_MIN:  cfg_gate_min  = val[15:0];
         CSR_FLOOR_MAX: cfg_floor_max = val[15:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(gate_setup_type s);
      settle();
      write_reg(CSR_ENDPOINT, s.endpoint);
      write_reg(CSR_CALIBRATE, s.calibrate);
      write_reg(CSR_ANNOUNCE, s.announce);
      write_reg(CSR_GAIN, s.gain);
      write_reg(CSR_RATE, s.rate);
      write_reg(CSR_GATE_MIN, s.gate_min);
      write_reg(CSR_FLOOR_MAX, s.floor_max);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------- tests

   // reset register values, still inside the calibration window
   task automatic check_power_on_defaults();
      send_sample(16'h8000, 1'b1, 1'b0);
      send_sample(16'h7FFF, 1'b1, 1'b0);
      send_sample(16'h0000, 1'b1, 1'b1);
      send_sample(16'h7FFF, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b0);
   endtask

   // floor and minimum both zero: loudness is all or nothing
   task automatic check_zero_gate();
      load_setup('{endpoint: 24'd5, calibrate: 24'd0, announce: 24'd2, gain: 24'd0,
                   rate: 24'h4000, gate_min: 24'd0, floor_max: 24'd0});
      send_sample(16'h0000, 1'b1, 1'b1);
      send_sample(16'h0005, 1'b1, 1'b0);
      send_sample(16'h0000, 1'b0, 1'b0);
      send_sample(16'h0000, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b1, 1'b0);
   endtask

   // all ones (upper bits masked off) and all zeros, then a fast floor decay
   task automatic check_register_extremes();
      load_setup('{default: 24'hFFFFFF});
      send_sample(16'h8000, 1'b1, 1'b1);
      send_sample(16'h7FFF, 1'b1, 1'b0);
      load_setup('{default: 24'h000000});
      send_sample(16'h0064, 1'b1, 1'b0);
      send_sample(16'h0000, 1'b1, 1'b0);
      load_setup('{endpoint: 24'd0, calibrate: 24'd0, announce: 24'd0, gain: 24'hFF,
                   rate: 24'hFFFF, gate_min: 24'd0, floor_max: 24'd0});
      send_sample(16'h0100, 1'b1, 1'b0);
      send_sample(16'hC000, 1'b1, 1'b0);
   endtask

   // quiet count walks past the announce and endpoint thresholds exactly
   task automatic check_quiet_thresholds();
      load_setup('{endpoint: 24'd9, calibrate: 24'd4, announce: 24'd3, gain: 24'd48,
                   rate: 24'h8000, gate_min: 24'd100, floor_max: 24'd655});
      send_chunk(2, 3000, 1'b1);
      repeat (10) send_sample(16'h0000, 1'b1, 1'b0);
      send_sample(16'h4E20, 1'b1, 1'b0);
   endtask

   // restart drops an open chunk
   task automatic check_chunk_boundaries();
      load_setup('{endpoint: 24'd4000, calibrate: 24'd100, announce: 24'd500,
                   gain: 24'd40, rate: 24'd2000, gate_min: 24'd50, floor_max: 24'd800});
      for (int i = 0; i < 5; i++) send_sample(pick_sample(1000), 1'b0, 1'b0);
      send_sample(16'h1234, 1'b1, 1'b1);
   endtask

   task automatic check_random_traffic();
      gate_setup_type s;
      int             goal, len, amp, r, c;
      bit             paused;
      for (int p = 0; p < 6; p++) begin
         s.endpoint  = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom_range(0, 3000));
         s.calibrate = {8'($urandom), 16'($urandom_range(0, 300))};
         s.announce  = {8'($urandom), 16'($urandom_range(0, 1500))};
         s.gain      = 24'($urandom);
         s.rate      = 24'($urandom);
         s.gate_min  = {8'($urandom),
                        ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(0, 2000))};
         s.floor_max = {8'($urandom), 16'($urandom_range(0, 4000))};
         load_setup(s);
         steady_run = (p == 2);
         paused = 1'b0;
         goal = samples_sent + 320;
         while (samples_sent < goal) begin
            if (p == 3 && !paused && samples_sent >= goal - 160) begin
               drain_results();
               paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 88) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
               c = $urandom_range(99);
               amp = (c < 50) ? $urandom_range(0, 300) :
                     (c < 80) ? $urandom_range(300, 4000) : 32768;
               send_chunk(len, amp, $urandom_range(19) == 0);
            end else begin
               // stray word: any sample, any marks
               send_sample(16'($urandom), 1'($urandom), $urandom_range(7) == 0);
            end
         end
         steady_run = 1'b0;
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      check_power_on_defaults();
      check_zero_gate();
      check_register_extremes();
      check_quiet_thresholds();
      check_chunk_boundaries();
      check_random_traffic();

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/angvad_pkg.sv
rtl/core/angvad_div.sv
rtl/core/adaptive_noise_gate_vad_core.sv
rtl/core/angvad_checker.sv
sim/adaptive_noise_gate_vad_core_test.sv
